/* src/sfsc_pkg.sv */
// ----------------------------------------------------------------------------
// sfsc_pkg: shared definitions for the sensor frame sync and checksum unit
// Frame geometry, header bytes and the result record passed between modules.
// ----------------------------------------------------------------------------
package sfsc_pkg;

  localparam int unsigned FRAME_BYTES = 32;  // legal range 12..64
  localparam int unsigned POS_W       = 6;
  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned NUM_WORDS   = 3;
  localparam int unsigned WORD_BASE   = 4;   // offset of the first PM word

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_CHKHI = POS_W'(FRAME_BYTES - 2);

  localparam logic [7:0] HDR_B0 = 8'h42;
  localparam logic [7:0] HDR_B1 = 8'h4D;
  localparam logic [7:0] HDR_B2 = 8'h00;
  localparam logic [7:0] HDR_B3 = 8'h1C;

  typedef struct packed {
    logic        valid;
    logic        frame_ok;
    logic [15:0] pm_small;
    logic [15:0] pm_medium;
    logic [15:0] pm_large;
  } sfsc_result_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = HDR_B0;
      2'd1:    b = HDR_B1;
      2'd2:    b = HDR_B2;
      2'd3:    b = HDR_B3;
      default: b = HDR_B0;
    endcase
    return b;
  endfunction

endpackage

/* src/sfsc_core.sv */
// ----------------------------------------------------------------------------
// sfsc_core: frame tracker
// Holds position, running sum, captured PM words and checksum high byte.
// Computes the result for the presented byte; state moves on when step_en.
// ----------------------------------------------------------------------------
module sfsc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic [7:0]            rx_byte,
  output sfsc_pkg::sfsc_result_t result
);
  import sfsc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      sum_r, sum_nxt;
  logic [15:0]      words_r [NUM_WORDS];
  logic [15:0]      words_nxt [NUM_WORDS];
  logic [7:0]       chk_hi_r, chk_hi_nxt;
  logic             in_hdr, at_last;
  logic [15:0]      byte_ext;

  assign in_hdr   = (pos_r < POS_W'(HDR_BYTES));
  assign at_last  = (pos_r >= POS_LAST);
  assign byte_ext = {8'h00, rx_byte};

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    chk_hi_nxt = chk_hi_r;
    for (int i = 0; i < NUM_WORDS; i++) begin
      words_nxt[i] = words_r[i];
    end

    if (in_hdr) begin
      if (rx_byte == hdr_byte(pos_r[1:0])) begin
        sum_nxt = ((pos_r == '0) ? 16'h0000 : sum_r) + byte_ext;
        pos_nxt = pos_r + 1'b1;
      end else begin
        // mismatching byte is dropped, not retried as a start byte
        pos_nxt = '0;
        sum_nxt = '0;
      end
    end else if (at_last) begin
      pos_nxt = '0;
      sum_nxt = '0;
    end else begin
      if (pos_r == POS_CHKHI) begin
        chk_hi_nxt = rx_byte;
      end else begin
        sum_nxt = sum_r + byte_ext;
        for (int i = 0; i < NUM_WORDS; i++) begin
          if (pos_r == POS_W'(WORD_BASE + 2 * i)) begin
            words_nxt[i] = {rx_byte, words_r[i][7:0]};
          end
          if (pos_r == POS_W'(WORD_BASE + 2 * i + 1)) begin
            words_nxt[i] = {words_r[i][15:8], rx_byte};
          end
        end
      end
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_comb begin
    result.valid     = at_last && !in_hdr;
    result.frame_ok  = ({chk_hi_r, rx_byte} == sum_r);
    result.pm_small  = words_r[0];
    result.pm_medium = words_r[1];
    result.pm_large  = words_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      chk_hi_r <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else if (step_en) begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      chk_hi_r <= chk_hi_nxt;
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_r[i] <= words_nxt[i];
      end
    end
  end

endmodule

/* src/sensor_frame_sync_checksum_unit.sv */
// ----------------------------------------------------------------------------
// sensor_frame_sync_checksum_unit: particulate sensor frame parser
// Header sync, 16-bit wrapping checksum and PM word capture, one byte a time.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake               Payload
// in_      in   in_valid / in_ready     in_rx_byte[7:0]
// out_     out  out_valid / out_ready   out_frame_ok, out_pm_small/medium/large
//
// One byte per cycle sustained unless a held result stalls a frame's last byte:
// input register, one stage of update logic, result register.
// A result appears only for the last byte of a frame.
// Synchronous active-low reset clears frame state and both valid flags.
// A held result stalls only a byte that itself ends a frame.
// ----------------------------------------------------------------------------
module sensor_frame_sync_checksum_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_ok,
  output logic [15:0] out_pm_small,
  output logic [15:0] out_pm_medium,
  output logic [15:0] out_pm_large
);
  import sfsc_pkg::*;

  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  logic         out_vld_r;
  sfsc_result_t res;
  sfsc_result_t out_r;
  logic         advance;

  sfsc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .rx_byte (in_byte_r),
    .result  (res)
  );

  // a byte without a result never waits on the output side
  assign advance  = in_vld_r && (!res.valid || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_frame_ok  = out_r.frame_ok;
  assign out_pm_small  = out_r.pm_small;
  assign out_pm_medium = out_r.pm_medium;
  assign out_pm_large  = out_r.pm_large;

endmodule

/* tb/sv/tb_sfsc_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sfsc_scoreboard_pkg: frame result scoreboard for the frame sync unit
// Tracks header sync, running sum and PM capture byte by byte, queues the
// frame result each completed frame should produce and checks the DUT output.
// ----------------------------------------------------------------------------
package tb_sfsc_scoreboard_pkg;
  import sfsc_pkg::*;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] pm_small;
    logic [15:0] pm_medium;
    logic [15:0] pm_large;
  } frame_result_t;

  class frame_scoreboard;
    logic [7:0]       sync_bytes [HDR_BYTES] = '{HDR_B0, HDR_B1, HDR_B2, HDR_B3};
    logic [POS_W-1:0] next_pos   = '0;
    logic [15:0]      frame_sum  = '0;
    logic [15:0]      pm_words [NUM_WORDS] = '{16'h0000, 16'h0000, 16'h0000};
    logic [7:0]       chk_hi     = '0;
    frame_result_t    expected_frames [$];
    int               errors     = 0;
    int               frames_ok  = 0;
    int               frames_bad = 0;

    function int pending();
      return expected_frames.size();
    endfunction

    // Called once per accepted input transfer.
    function void note_rx_byte(logic [7:0] b);
      frame_result_t r;
      int            idx;
      if (next_pos < HDR_BYTES) begin
        if (b == sync_bytes[next_pos[1:0]]) begin
          frame_sum = 16'((next_pos == 0 ? 16'd0 : frame_sum) + b);
          next_pos  = next_pos + 1'b1;
        end else begin
          // the failing byte is not retried as a new start
          next_pos  = '0;
          frame_sum = '0;
        end
        return;
      end
      if (next_pos >= POS_LAST) begin
        r.frame_ok  = ({chk_hi, b} == frame_sum);
        r.pm_small  = pm_words[0];
        r.pm_medium = pm_words[1];
        r.pm_large  = pm_words[2];
        expected_frames.push_back(r);
        if (r.frame_ok) frames_ok++;
        else frames_bad++;
        next_pos  = '0;
        frame_sum = '0;
        return;
      end
      if (next_pos == POS_CHKHI) begin
        chk_hi = b;
      end else begin
        frame_sum = 16'(frame_sum + b);
        if (next_pos < WORD_BASE + 2 * NUM_WORDS) begin
          idx = (int'(next_pos) - WORD_BASE) >> 1;
          if (!next_pos[0]) pm_words[idx][15:8] = b;
          else pm_words[idx][7:0] = b;
        end
      end
      next_pos = next_pos + 1'b1;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Called once per accepted output transfer.
    function void check_frame_result(logic ok, logic [15:0] s, logic [15:0] m,
                                     logic [15:0] l);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame result, expected none, actual ok=%b pm=%h/%h/%h",
                 $time, ok, s, m, l);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      compare_field("frame_ok", 16'(want.frame_ok), 16'(ok));
      compare_field("pm_small", want.pm_small, s);
      compare_field("pm_medium", want.pm_medium, m);
      compare_field("pm_large", want.pm_large, l);
    endfunction
  endclass

endpackage

/* tb/sv/tb_sensor_frame_sync_checksum_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_sync_checksum_unit: testbench for the frame sync unit
// Directed header mismatches and edge frames, then mostly well-formed random
// frames mixed with broken headers and noise, under random source gaps and
// sink stalls. Every output transfer is checked against the scoreboard.
// ----------------------------------------------------------------------------
module tb_sensor_frame_sync_checksum_unit;
  import sfsc_pkg::*;
  import tb_sfsc_scoreboard_pkg::*;

  localparam int TARGET_BYTES   = 1000;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte    = 8'h00;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_frame_ok;
  logic [15:0] out_pm_small;
  logic [15:0] out_pm_medium;
  logic [15:0] out_pm_large;

  frame_scoreboard sb;
  int bytes_sent     = 0;
  int src_calm_left  = 0;
  int sink_calm_left = 0;

  sensor_frame_sync_checksum_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_ok  (out_frame_ok),
    .out_pm_small  (out_pm_small),
    .out_pm_medium (out_pm_medium),
    .out_pm_large  (out_pm_large)
  );

  always #5 clk = ~clk;

  // Gap draw shared by both sides; occasional stretches run back to back.
  function automatic int draw_gap(ref int calm_left, input int calm_max);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(1, calm_max);
    return $urandom_range(0, 9);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(src_calm_left, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] pm_s, input logic [15:0] pm_m,
                            input logic [15:0] pm_l, input bit bad_sum,
                            input bit rand_fill, input logic [7:0] fill_val);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] sum;
    fb[0] = HDR_B0;
    fb[1] = HDR_B1;
    fb[2] = HDR_B2;
    fb[3] = HDR_B3;
    fb[4] = pm_s[15:8];
    fb[5] = pm_s[7:0];
    fb[6] = pm_m[15:8];
    fb[7] = pm_m[7:0];
    fb[8] = pm_l[15:8];
    fb[9] = pm_l[7:0];
    for (int i = 10; i < FRAME_BYTES - 2; i++)
      fb[i] = rand_fill ? 8'($urandom) : fill_val;
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 2; i++) sum = 16'(sum + fb[i]);
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
    fb[FRAME_BYTES-2] = sum[15:8];
    fb[FRAME_BYTES-1] = sum[7:0];
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[i]);
  endtask

  function automatic logic [15:0] rand_pm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sink: random stalls between output transfers.
  initial begin : result_sink
    int gap;
    wait (rst_n);
    forever begin
      gap = draw_gap(sink_calm_left, 4);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_frame_result(out_frame_ok, out_pm_small, out_pm_medium, out_pm_large);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int sel;
    int n;
    sb = new;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // header mismatch at each position
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h4D);
    send_byte(HDR_B0); send_byte(8'h55);
    send_byte(HDR_B0); send_byte(HDR_B1); send_byte(8'h01);
    send_byte(HDR_B0); send_byte(HDR_B1); send_byte(HDR_B2); send_byte(8'h1D);
    // repeated start byte: the second one must not begin a header
    send_byte(HDR_B0); send_byte(HDR_B0);
    send_byte(HDR_B1); send_byte(HDR_B2); send_byte(HDR_B3);
    // all-ones frame, header inside an all-zero-fill payload with a bad checksum, then an all-zero frame
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 8'hFF);
    send_frame(16'h424D, 16'h001C, 16'h0000, 1'b1, 1'b0, 8'h00);
    send_frame(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00);

    while (bytes_sent < TARGET_BYTES) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        send_frame(rand_pm(), rand_pm(), rand_pm(), $urandom_range(0, 3) == 0,
                   1'b1, 8'h00);
      end else if (sel < 88) begin
        // header cut short by a random byte
        n = $urandom_range(1, 3);
        if (n >= 1) send_byte(HDR_B0);
        if (n >= 2) send_byte(HDR_B1);
        if (n >= 3) send_byte(HDR_B2);
        send_byte(8'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes with random gaps and stalls", bytes_sent);
    $display("Frames completed: %0d with good checksum, %0d with bad checksum",
             sb.frames_ok, sb.frames_bad);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
src/sfsc_pkg.sv
src/sfsc_core.sv
src/sensor_frame_sync_checksum_unit.sv
tb/sv/tb_sfsc_scoreboard_pkg.sv
tb/sv/tb_sensor_frame_sync_checksum_unit.sv
